### hw/rtl/ordered_list_store_with_remove_min_top_defines.svh
// Assertion macros for the ordered list store.
// Define NO_ASSERTIONS to compile them out.
`ifndef ORDERED_LIST_STORE_WITH_REMOVE_MIN_TOP_DEFINES_SVH
`define ORDERED_LIST_STORE_WITH_REMOVE_MIN_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, quiet in reset
`define OLSRM_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);
// next-cycle implication
`define OLSRM_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);
`else
`define OLSRM_ASSERT_NOW(lbl, cond, conseq, msg)
`define OLSRM_ASSERT_NEXT(lbl, cond, conseq, msg)
`endif

`endif

### hw/rtl/olsrm_pkg.sv
`default_nettype none

package olsrm_pkg;

  // fixed field widths of the word ports
  localparam int REQ_W  = 3;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT_AT  = 3'd0,
    REQ_INSERT_ORD = 3'd1,
    REQ_DELETE_AT  = 3'd2,
    REQ_SEARCH     = 3'd3,
    REQ_REMOVE_MIN = 3'd4,
    REQ_TRAVERSE   = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_POS   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_DEL,
    S_MIN,
    S_PACK,
    S_TRAV,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/ordered_list_store_with_remove_min_top.sv
// Bounded list of up to CAPACITY signed values held packed from index 0 in one
// synchronous RAM (one write port, one read port, read data registered). A
// request is taken only while the sequencer is idle; the result word sits in an
// output register, so a new request may be taken while it waits. The RAM is
// walked one entry per cycle while a traverse is not stalled by the result side.
// insert_ordered is a search pass that stops at the insertion point plus the
// shift; remove_min is a minimum pass and a compaction pass. No clearing pass
// after reset: only entries below the count are ever read. Request types 6 and
// 7 are dropped.
`default_nettype none

module ordered_list_store_with_remove_min_top #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [olsrm_pkg::REQ_W-1:0]   req_type,
  input  logic signed [VALUE_WIDTH-1:0] item_value,
  input  logic [olsrm_pkg::IDX_W-1:0]   position,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [olsrm_pkg::STAT_W-1:0]  status,
  output logic signed [VALUE_WIDTH-1:0] result_value,
  output logic [olsrm_pkg::IDX_W-1:0]   result_index,
  output logic [olsrm_pkg::IDX_W-1:0]   removed_count,
  output logic [olsrm_pkg::IDX_W-1:0]   list_count,
  output logic                          last
);
  import olsrm_pkg::*;

`include "ordered_list_store_with_remove_min_top_defines.svh"

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // element store
  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic                   re, we;
  logic [AW-1:0]          raddr, waddr;
  logic [VALUE_WIDTH-1:0] wdata, rdata;

  // control and working registers
  state_t                 state, state_next;
  logic [CW-1:0]          count, count_next;
  req_t                   op, op_next;
  logic [VALUE_WIDTH-1:0] val, val_next;
  logic [AW-1:0]          pos, pos_next;
  logic [CW-1:0]          ptr, ptr_next;
  logic                   dv;
  logic [AW-1:0]          didx;
  logic [VALUE_WIDTH-1:0] minv, minv_next;
  logic [CW-1:0]          wj, wj_next;

  // pending single result
  status_t                rstat, rstat_next;
  logic [VALUE_WIDTH-1:0] rval, rval_next;
  logic [AW-1:0]          ridx, ridx_next;
  logic [CW-1:0]          rrem, rrem_next;

  // output word load
  logic                   out_load, out_free;
  status_t                ld_stat;
  logic [VALUE_WIDTH-1:0] ld_val;
  logic [AW-1:0]          ld_idx;
  logic [CW-1:0]          ld_rem;
  logic                   ld_last;

  // request decode
  status_t                dec_stat;
  state_t                 dec_state;

  // shared conditions
  logic [IDX_W-1:0]       n7;
  logic                   full, empty, more, drained, hit, hit_v, last_elem;
  logic [CW-1:0]          ptr_m1;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign n7        = IDX_W'(count);
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign more      = (ptr < count);
  assign drained   = !dv && !more;
  assign ptr_m1    = ptr - CW'(1);
  assign hit       = (op == REQ_SEARCH) ? (rdata == val)
                                        : ($signed(rdata) >= $signed(val));
  assign hit_v     = dv && hit;
  assign last_elem = ((CW'(didx) + CW'(1)) == count);

  // decode of an incoming request
  always_comb begin
    dec_stat  = ST_OK;
    dec_state = S_IDLE;
    unique case (req_t'(req_type))
      REQ_INSERT_AT: begin
        if (full) begin
          dec_stat  = ST_FULL;
          dec_state = S_EMIT;
        end else if (position > n7) begin
          dec_stat  = ST_BAD_POS;
          dec_state = S_EMIT;
        end else begin
          dec_state = S_SHIFT;
        end
      end
      REQ_INSERT_ORD: begin
        if (full) begin
          dec_stat  = ST_FULL;
          dec_state = S_EMIT;
        end else begin
          dec_state = S_FIND;
        end
      end
      REQ_DELETE_AT: begin
        if (empty) begin
          dec_stat  = ST_EMPTY;
          dec_state = S_EMIT;
        end else if (position >= n7) begin
          dec_stat  = ST_BAD_POS;
          dec_state = S_EMIT;
        end else begin
          dec_state = S_DEL;
        end
      end
      REQ_SEARCH: begin
        dec_state = S_FIND;
      end
      REQ_REMOVE_MIN: begin
        if (empty) begin
          dec_stat  = ST_EMPTY;
          dec_state = S_EMIT;
        end else begin
          dec_state = S_MIN;
        end
      end
      REQ_TRAVERSE: begin
        if (empty) begin
          dec_stat  = ST_EMPTY;
          dec_state = S_EMIT;
        end else begin
          dec_state = S_TRAV;
        end
      end
      default: begin
        dec_state = S_IDLE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = dec_state;
      end
      S_FIND: begin
        if (hit_v || drained) state_next = (op == REQ_SEARCH) ? S_EMIT : S_SHIFT;
      end
      S_SHIFT: begin
        if (!(ptr > CW'(pos)) && !dv) state_next = S_EMIT;
      end
      S_DEL: begin
        if (drained) state_next = S_EMIT;
      end
      S_MIN: begin
        if (drained) state_next = S_PACK;
      end
      S_PACK: begin
        if (drained) state_next = S_EMIT;
      end
      S_TRAV: begin
        if (dv && out_free && last_elem) state_next = S_IDLE;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath, RAM ports and output word
  always_comb begin
    re         = 1'b0;
    we         = 1'b0;
    raddr      = ptr[AW-1:0];
    waddr      = didx;
    wdata      = rdata;
    count_next = count;
    op_next    = op;
    val_next   = val;
    pos_next   = pos;
    ptr_next   = ptr;
    minv_next  = minv;
    wj_next    = wj;
    rstat_next = rstat;
    rval_next  = rval;
    ridx_next  = ridx;
    rrem_next  = rrem;
    out_load   = 1'b0;
    ld_stat    = rstat;
    ld_val     = rval;
    ld_idx     = ridx;
    ld_rem     = rrem;
    ld_last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next    = req_t'(req_type);
          val_next   = item_value;
          pos_next   = position[AW-1:0];
          rstat_next = dec_stat;
          rval_next  = '0;
          ridx_next  = '0;
          rrem_next  = '0;
          if (dec_state == S_SHIFT) begin
            ptr_next = count;
          end else if (dec_state == S_DEL) begin
            ptr_next = position[CW-1:0];
          end else begin
            ptr_next = '0;
          end
        end
      end
      // walk from the head until a hit or the end
      S_FIND: begin
        if (hit_v) begin
          if (op == REQ_SEARCH) begin
            rstat_next = ST_OK;
            rval_next  = rdata;
            ridx_next  = didx;
          end else begin
            pos_next = didx;
            ptr_next = count;
          end
        end else if (drained) begin
          if (op == REQ_SEARCH) begin
            rstat_next = ST_NOT_FOUND;
          end else begin
            pos_next = count[AW-1:0];
            ptr_next = count;
          end
        end else if (more) begin
          re       = 1'b1;
          ptr_next = ptr + CW'(1);
        end
      end
      // open a gap at pos, moving the tail up one entry per cycle
      S_SHIFT: begin
        if (dv) begin
          we    = 1'b1;
          waddr = didx + AW'(1);
          wdata = rdata;
        end
        if (ptr > CW'(pos)) begin
          re       = 1'b1;
          raddr    = ptr_m1[AW-1:0];
          ptr_next = ptr_m1;
        end else if (!dv) begin
          we         = 1'b1;
          waddr      = pos;
          wdata      = val;
          count_next = count + CW'(1);
          rstat_next = ST_OK;
          ridx_next  = pos;
        end
      end
      // capture entry pos, then close the gap
      S_DEL: begin
        if (more) begin
          re       = 1'b1;
          ptr_next = ptr + CW'(1);
        end
        if (dv) begin
          if (didx == pos) begin
            rval_next = rdata;
          end else begin
            we    = 1'b1;
            waddr = didx - AW'(1);
            wdata = rdata;
          end
        end
        if (drained) begin
          count_next = count - CW'(1);
          rstat_next = ST_OK;
          ridx_next  = pos;
          rrem_next  = CW'(1);
        end
      end
      // minimum pass
      S_MIN: begin
        if (more) begin
          re       = 1'b1;
          ptr_next = ptr + CW'(1);
        end
        if (dv && ((didx == '0) || ($signed(rdata) < $signed(minv)))) begin
          minv_next = rdata;
        end
        if (drained) begin
          ptr_next = '0;
          wj_next  = '0;
        end
      end
      // compaction pass, keeping every entry that differs from the minimum
      S_PACK: begin
        if (more) begin
          re       = 1'b1;
          ptr_next = ptr + CW'(1);
        end
        if (dv && (rdata != minv)) begin
          we      = 1'b1;
          waddr   = wj[AW-1:0];
          wdata   = rdata;
          wj_next = wj + CW'(1);
        end
        if (drained) begin
          count_next = wj;
          rstat_next = ST_OK;
          rval_next  = minv;
          ridx_next  = '0;
          rrem_next  = count - wj;
        end
      end
      // one word per entry; read data holds while the output is stalled
      S_TRAV: begin
        if (more && (!dv || out_free)) begin
          re       = 1'b1;
          ptr_next = ptr + CW'(1);
        end
        if (dv && out_free) begin
          out_load = 1'b1;
          ld_stat  = ST_OK;
          ld_val   = rdata;
          ld_idx   = didx;
          ld_rem   = '0;
          ld_last  = last_elem;
        end
      end
      S_EMIT: begin
        out_load = out_free;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // element RAM
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dv        <= re || (dv && (state == S_TRAV) && !out_free);
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    op    <= op_next;
    val   <= val_next;
    pos   <= pos_next;
    ptr   <= ptr_next;
    minv  <= minv_next;
    wj    <= wj_next;
    rstat <= rstat_next;
    rval  <= rval_next;
    ridx  <= ridx_next;
    rrem  <= rrem_next;
    if (re) didx <= raddr;
    if (out_load) begin
      status        <= ld_stat;
      result_value  <= ld_val;
      result_index  <= IDX_W'(ld_idx);
      removed_count <= IDX_W'(ld_rem);
      list_count    <= IDX_W'(count_next);
      last          <= ld_last;
    end
  end

  // checks
  `OLSRM_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(CAPACITY), "count above capacity")
  `OLSRM_ASSERT_NOW(a_no_rw_clash, we && re, waddr != raddr, "read and write hit one entry")
  `OLSRM_ASSERT_NOW(a_count_at_end, count != count_next, state_next == S_EMIT,
                    "count moved outside the end of a request")
  `OLSRM_ASSERT_NEXT(a_trav_hold, (state == S_TRAV) && dv && !out_free, $stable(rdata),
                     "stalled traverse word lost")

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import olsrm_pkg::*;

  localparam int CAP = 64;
  localparam int PHASE_ITEMS = 104;
  localparam int HOLD_CYCLES = 400;
  // remove-min over a full list is the slowest request: two passes plus slack
  localparam int DRAIN_CYCLES = 4 * CAP + 50;
  localparam int MAX_PRINTS = 40;

  // request codes the block ignores
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

  // random episode shapes and value styles
  localparam int EP_GROW = 0;
  localparam int EP_SHRINK = 1;
  localparam int EP_MIXED = 2;
  localparam int VAL_NARROW = 0;
  localparam int VAL_EDGE = 1;
  localparam int VAL_WIDE = 2;

  localparam int PHASE_GAP [4] = '{0, 81, 0, 18};
  localparam int PHASE_STALL [4] = '{0, 0, 81, 18};

  typedef struct packed {
    status_t           st;
    logic signed [31:0] val;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  rem;
    logic [IDX_W-1:0]  cnt;
    logic              last;
  } result_word_t;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic signed [31:0] val;
    logic [IDX_W-1:0]   pos;
    int                 reps;
    bit                 rnd;
    bit                 typed;
    result_word_t       res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] req_type = '0;
  logic signed [31:0] item_value = '0;
  logic [IDX_W-1:0] position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic signed [31:0] result_value;
  logic [IDX_W-1:0] result_index;
  logic [IDX_W-1:0] removed_count;
  logic [IDX_W-1:0] list_count;
  logic last;

  // shadow of the list contents
  logic signed [31:0] shadow_vals [CAP];
  int shadow_len = 0;

  result_word_t pending_words [$];
  result_word_t fresh_words [$];

  int fail_count = 0;
  int words_checked = 0;
  int items_sent = 0;
  int full_hits = 0;
  int list_wipes = 0;

  int gap_pct = 0;
  int stall_pct = 0;
  int ep_kind = EP_MIXED;
  int ep_left = 0;
  int val_mode = VAL_WIDE;

  logic hold_flip = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  ordered_list_store_with_remove_min_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .item_value   (item_value),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_value (result_value),
    .result_index (result_index),
    .removed_count(removed_count),
    .list_count   (list_count),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h (word %0d)",
                                name, got, want, words_checked));
  endtask

  // open a slot at idx and drop the value in
  task automatic place_value(input int idx, input logic signed [31:0] v);
    for (int i = shadow_len; i > idx; i--) shadow_vals[i] = shadow_vals[i - 1];
    shadow_vals[idx] = v;
    shadow_len++;
  endtask

  // advance the shadow list by one request and collect the words it yields
  task automatic apply_request(input logic [REQ_W-1:0] req, input logic signed [31:0] v,
                               input logic [IDX_W-1:0] p);
    int n;
    int k;
    logic signed [31:0] lo;
    result_word_t w;
    n = shadow_len;
    w = '0;
    w.last = 1'b1;
    fresh_words.delete();
    case (req)
      REQ_INSERT_AT: begin
        if (n >= CAP) w.st = ST_FULL;
        else if (int'(p) > n) w.st = ST_BAD_POS;
        else begin
          place_value(int'(p), v);
          w.idx = p;
        end
      end
      REQ_INSERT_ORD: begin
        if (n >= CAP) w.st = ST_FULL;
        else begin
          // goes ahead of the first element not below it
          k = 0;
          while (k < n && shadow_vals[k] < v) k++;
          place_value(k, v);
          w.idx = IDX_W'(k);
        end
      end
      REQ_DELETE_AT: begin
        if (n == 0) w.st = ST_EMPTY;
        else if (int'(p) >= n) w.st = ST_BAD_POS;
        else begin
          w.val = shadow_vals[p];
          for (int i = int'(p); i < n - 1; i++) shadow_vals[i] = shadow_vals[i + 1];
          shadow_len = n - 1;
          w.idx = p;
          w.rem = 1;
        end
      end
      REQ_SEARCH: begin
        w.st = ST_NOT_FOUND;
        for (int i = 0; i < n; i++) begin
          if (shadow_vals[i] == v) begin
            w.st = ST_OK;
            w.val = v;
            w.idx = IDX_W'(i);
            break;
          end
        end
      end
      REQ_REMOVE_MIN: begin
        if (n == 0) w.st = ST_EMPTY;
        else begin
          lo = shadow_vals[0];
          for (int i = 1; i < n; i++) if (shadow_vals[i] < lo) lo = shadow_vals[i];
          // compact the survivors, order kept
          k = 0;
          for (int i = 0; i < n; i++) begin
            if (shadow_vals[i] != lo) begin
              shadow_vals[k] = shadow_vals[i];
              k++;
            end
          end
          shadow_len = k;
          w.val = lo;
          w.rem = IDX_W'(n - k);
          if (k == 0) list_wipes++;
        end
      end
      REQ_TRAVERSE: begin
        if (n == 0) w.st = ST_EMPTY;
        else begin
          for (int i = 0; i < n; i++) begin
            w.val = shadow_vals[i];
            w.idx = IDX_W'(i);
            w.cnt = IDX_W'(n);
            w.last = (i == n - 1);
            fresh_words.push_back(w);
          end
          return;
        end
      end
      default: return;
    endcase
    w.cnt = IDX_W'(shadow_len);
    if (w.st == ST_FULL) full_hits++;
    fresh_words.push_back(w);
  endtask

  function automatic logic signed [31:0] draw_value();
    case (val_mode)
      VAL_NARROW: return $signed(32'($urandom_range(0, 6))) - 32'sd3;
      VAL_EDGE: begin
        case ($urandom_range(0, 5))
          0: return VMIN;
          1: return VMAX;
          2: return 32'sd0;
          3: return -32'sd1;
          4: return VMIN + 32'sd1;
          default: return VMAX - 32'sd1;
        endcase
      end
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic stim_row_t typed_row(logic [REQ_W-1:0] req, logic signed [31:0] v,
                                          int p, status_t st, logic signed [31:0] rv,
                                          int ri, int rc, int lc);
    stim_row_t r;
    r.req = req;
    r.val = v;
    r.pos = IDX_W'(p);
    r.reps = 1;
    r.rnd = 1'b0;
    r.typed = 1'b1;
    r.res = '{st: st, val: rv, idx: IDX_W'(ri), rem: IDX_W'(rc), cnt: IDX_W'(lc),
              last: 1'b1};
    return r;
  endfunction

  function automatic stim_row_t pred_row(logic [REQ_W-1:0] req, logic signed [31:0] v,
                                         int p, int reps, bit rnd);
    stim_row_t r;
    r.req = req;
    r.val = v;
    r.pos = IDX_W'(p);
    r.reps = reps;
    r.rnd = rnd;
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  // offer one word, hold it until taken, then book its expected results
  task automatic send_word(input logic [REQ_W-1:0] req, input logic signed [31:0] v,
                           input logic [IDX_W-1:0] p, input bit typed,
                           input result_word_t typed_word);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    item_value <= v;
    position <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_request(req, v, p);
    if (typed) pending_words.push_back(typed_word);
    else foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
    items_sent++;
  endtask

  // episodes: grow towards full, shrink towards empty, or a mix; plus noise
  task automatic pick_random_item(output logic [REQ_W-1:0] req,
                                  output logic signed [31:0] v,
                                  output logic [IDX_W-1:0] p);
    int r;
    if (ep_left == 0) begin
      ep_kind = $urandom_range(EP_GROW, EP_MIXED);
      val_mode = $urandom_range(VAL_NARROW, VAL_WIDE);
      ep_left = $urandom_range(15, 60);
    end
    ep_left--;
    v = draw_value();
    p = IDX_W'($urandom_range(0, shadow_len));
    if ($urandom_range(99) < 6) begin
      req = REQ_W'($urandom_range(0, 7));
      p = IDX_W'($urandom_range(0, 127));
      return;
    end
    if ($urandom_range(99) < 8) p = IDX_W'($urandom_range(0, 127));
    r = $urandom_range(99);
    case (ep_kind)
      EP_GROW:
        req = (r < 45) ? REQ_INSERT_AT : (r < 85) ? REQ_INSERT_ORD :
              (r < 93) ? REQ_SEARCH : (r < 97) ? REQ_TRAVERSE : REQ_DELETE_AT;
      EP_SHRINK:
        req = (r < 40) ? REQ_DELETE_AT : (r < 70) ? REQ_REMOVE_MIN :
              (r < 85) ? REQ_SEARCH : (r < 91) ? REQ_TRAVERSE : REQ_INSERT_ORD;
      default:
        req = (r < 22) ? REQ_INSERT_AT : (r < 44) ? REQ_INSERT_ORD :
              (r < 60) ? REQ_DELETE_AT : (r < 76) ? REQ_SEARCH :
              (r < 92) ? REQ_REMOVE_MIN : REQ_TRAVERSE;
    endcase
    // searches mostly look for something that is there
    if (req == REQ_SEARCH && shadow_len != 0 && $urandom_range(99) < 60)
      v = shadow_vals[$urandom_range(0, shadow_len - 1)];
  endtask

  // result side: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_flip != hold_seen) begin
      hold_seen <= hold_flip;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare each taken result word with the oldest one outstanding
  always @(posedge clk) begin
    result_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("result word %0d with nothing outstanding", words_checked));
      end else begin
        w = pending_words.pop_front();
        compare_field("status", 32'(status), 32'(w.st));
        compare_field("result_value", result_value, w.val);
        compare_field("result_index", 32'(result_index), 32'(w.idx));
        compare_field("removed_count", 32'(removed_count), 32'(w.rem));
        compare_field("list_count", 32'(list_count), 32'(w.cnt));
        compare_field("last", 32'(last), 32'(w.last));
      end
      words_checked++;
    end
  end

  initial begin
    stim_row_t rows [$];
    logic [REQ_W-1:0] rq;
    logic signed [31:0] v;
    logic [IDX_W-1:0] p;

    // empty-list answers, then build min/max/duplicate contents by hand
    rows.push_back(typed_row(REQ_TRAVERSE, 0, 0, ST_EMPTY, 0, 0, 0, 0));
    rows.push_back(typed_row(REQ_DELETE_AT, 0, 0, ST_EMPTY, 0, 0, 0, 0));
    rows.push_back(typed_row(REQ_REMOVE_MIN, 0, 0, ST_EMPTY, 0, 0, 0, 0));
    rows.push_back(typed_row(REQ_SEARCH, 5, 0, ST_NOT_FOUND, 0, 0, 0, 0));
    rows.push_back(typed_row(REQ_INSERT_AT, 1, 1, ST_BAD_POS, 0, 0, 0, 0));
    rows.push_back(typed_row(REQ_INSERT_AT, VMAX, 0, ST_OK, 0, 0, 0, 1));
    rows.push_back(typed_row(REQ_INSERT_AT, VMIN, 0, ST_OK, 0, 0, 0, 2));
    rows.push_back(typed_row(REQ_INSERT_ORD, -1, 0, ST_OK, 0, 1, 0, 3));
    // equal value lands ahead of its copy
    rows.push_back(typed_row(REQ_INSERT_ORD, -1, 0, ST_OK, 0, 1, 0, 4));
    rows.push_back(typed_row(REQ_INSERT_ORD, VMIN, 0, ST_OK, 0, 0, 0, 5));
    // position equal to the count appends
    rows.push_back(typed_row(REQ_INSERT_AT, 7, 5, ST_OK, 0, 5, 0, 6));
    rows.push_back(typed_row(REQ_INSERT_AT, 3, 127, ST_BAD_POS, 0, 0, 0, 6));
    rows.push_back(typed_row(REQ_SEARCH, -1, 0, ST_OK, -1, 2, 0, 6));
    rows.push_back(typed_row(REQ_SEARCH, 12345, 0, ST_NOT_FOUND, 0, 0, 0, 6));
    rows.push_back(pred_row(REQ_TRAVERSE, 0, 0, 1, 1'b0));
    rows.push_back(typed_row(REQ_DELETE_AT, 0, 6, ST_BAD_POS, 0, 0, 0, 6));
    rows.push_back(typed_row(REQ_DELETE_AT, 0, 64, ST_BAD_POS, 0, 0, 0, 6));
    rows.push_back(typed_row(REQ_REMOVE_MIN, 0, 0, ST_OK, VMIN, 0, 2, 4));
    rows.push_back(typed_row(REQ_DELETE_AT, 0, 3, ST_OK, 7, 3, 1, 3));
    rows.push_back(pred_row(REQ_SPARE_6, -1, 127, 1, 1'b0));
    rows.push_back(pred_row(REQ_SPARE_7, 0, 0, 1, 1'b0));
    rows.push_back(pred_row(REQ_INSERT_ORD, VMAX, 0, 1, 1'b0));
    // top up to capacity, then the full answers and a full-length walk
    rows.push_back(pred_row(REQ_INSERT_ORD, 0, 0, CAP - 4, 1'b1));
    rows.push_back(typed_row(REQ_INSERT_AT, 1, 0, ST_FULL, 0, 0, 0, CAP));
    rows.push_back(typed_row(REQ_INSERT_ORD, 1, 0, ST_FULL, 0, 0, 0, CAP));
    rows.push_back(pred_row(REQ_TRAVERSE, 0, 0, 1, 1'b0));
    rows.push_back(pred_row(REQ_REMOVE_MIN, 0, 0, 1, 1'b0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    val_mode = VAL_WIDE;
    foreach (rows[r]) begin
      repeat (rows[r].reps) begin
        v = rows[r].rnd ? draw_value() : rows[r].val;
        send_word(rows[r].req, v, rows[r].pos, rows[r].typed, rows[r].res);
      end
    end

    // random part, one idling pattern per phase
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = PHASE_GAP[ph];
      stall_pct <= PHASE_STALL[ph];
      // long hold-off on the result side so the input backs up
      if (ph == 0) hold_flip <= ~hold_flip;
      repeat (PHASE_ITEMS) begin
        pick_random_item(rq, v, p);
        send_word(rq, v, p, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    stall_pct <= 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, checked %0d result words; list full %0d times, ",
             items_sent, words_checked, full_hits);
    $display("emptied by remove-min %0d times; %0d mismatches.", list_wipes, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timed out with %0d result words outstanding.", pending_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
